// File: src/ile_pkg.sv
// Package for the indexed list engine: payload structs, operation and status codes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package ile_pkg;

  localparam int CAPACITY    = 64;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int VALUE_WIDTH = 32;

  typedef enum logic [2:0] {
    ACT_INSERT    = 3'd0,
    ACT_REMOVE    = 3'd1,
    ACT_READ      = 3'd2,
    ACT_OVERWRITE = 3'd3,
    ACT_MEMBER    = 3'd4,
    ACT_COMPARE   = 3'd5,
    ACT_SWAP      = 3'd6,
    ACT_CLEAR     = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BADPOS = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_SAME   = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef struct packed {
    action_t                       action;
    logic signed [VALUE_WIDTH-1:0] item_value;
    logic [6:0]                    position;
    logic [5:0]                    other_position;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] read_value;
    logic                          match;
    status_t                       status;
    logic [6:0]                    item_count;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LOOK_RD,
    S_LOOK_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SW_A,
    S_SW_B,
    S_SW_C,
    S_SW_D,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RA_POS,
    RA_POS2,
    RA_IDX,
    RA_NEIGH
  } rsel_t;

  typedef enum logic [1:0] {
    WA_POS_VAL,
    WA_IDX_RD,
    WA_POS_RD,
    WA_POS2_TMP
  } wsel_t;

  typedef struct packed {
    logic  load_req;
    logic  start;
    logic  rd_en;
    rsel_t rsel;
    logic  wr_en;
    wsel_t wsel;
    logic  idx_step;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  cnt_clr;
    logic  cap_tmp;
    logic  cap_look;
    logic  scan_chk;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    err;
    logic    idx_eq_pos;
    logic    idx_last;
    logic    idx_eq_cnt;
    logic    out_free;
  } stat_t;

endpackage

// File: src/ile_ctrl.sv
// Controller state machine of the indexed list engine.
// Depends on ile_pkg; drives the command bundle of ile_dp.
`timescale 1ns / 1ps
module ile_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ile_pkg::stat_t st,
  output ile_pkg::cmd_t  cmd
);
  import ile_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.start = 1'b1;
        if (st.err) begin
          state_nxt = S_DONE;
        end else begin
          case (st.act)
            ACT_INSERT, ACT_REMOVE: state_nxt = S_SHIFT_RD;
            ACT_READ, ACT_COMPARE:  state_nxt = S_LOOK_RD;
            ACT_OVERWRITE: begin
              cmd.wr_en = 1'b1;
              cmd.wsel  = WA_POS_VAL;
              state_nxt = S_DONE;
            end
            ACT_MEMBER: state_nxt = S_SCAN_RD;
            ACT_SWAP:   state_nxt = S_SW_A;
            default: begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_DONE;
            end
          endcase
        end
      end
      S_SHIFT_RD: begin
        if (st.act == ACT_INSERT && st.idx_eq_pos) begin
          cmd.wr_en   = 1'b1;
          cmd.wsel    = WA_POS_VAL;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end else if (st.act != ACT_INSERT && st.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rsel  = RA_NEIGH;
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wsel     = WA_IDX_RD;
        cmd.idx_step = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_LOOK_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rsel  = RA_POS;
        state_nxt = S_LOOK_CHK;
      end
      S_LOOK_CHK: begin
        cmd.cap_look = 1'b1;
        state_nxt    = S_DONE;
      end
      S_SCAN_RD: begin
        if (st.idx_eq_cnt) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rsel     = RA_IDX;
          cmd.idx_step = 1'b1;
          state_nxt    = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        state_nxt    = S_SCAN_RD;
      end
      S_SW_A: begin
        cmd.rd_en = 1'b1;
        cmd.rsel  = RA_POS;
        state_nxt = S_SW_B;
      end
      S_SW_B: begin
        cmd.rd_en   = 1'b1;
        cmd.rsel    = RA_POS2;
        cmd.cap_tmp = 1'b1;
        state_nxt   = S_SW_C;
      end
      S_SW_C: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = WA_POS_RD;
        state_nxt = S_SW_D;
      end
      S_SW_D: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = WA_POS2_TMP;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: src/ile_dp.sv
// Datapath of the indexed list engine: cell memory, count, request registers,
// walk index, checks and the result register. Depends on ile_pkg.
`timescale 1ns / 1ps
module ile_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  ile_pkg::in_t   in_data,
  input  ile_pkg::cmd_t  cmd,
  output ile_pkg::stat_t st,
  output logic           out_valid,
  input  logic           out_ready,
  output ile_pkg::out_t  out_data
);
  import ile_pkg::*;

  logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] rdata_r, tmp_r, rd_r;
  in_t                           req_r;
  logic [CNT_W-1:0]              count_r, idx_r;
  logic                          match_r, out_valid_r;
  status_t                       status_r, st_calc;
  out_t                          out_r;
  logic [ADDR_W-1:0]             raddr, waddr;
  logic signed [VALUE_WIDTH-1:0] wdata;
  logic [CNT_W-1:0]              neigh, pos2_ext;

  assign pos2_ext = CNT_W'(req_r.other_position);
  assign neigh    = (req_r.action == ACT_INSERT) ? idx_r - CNT_W'(1) : idx_r + CNT_W'(1);

  // Validity of the latched request against the current count.
  always_comb begin
    st_calc = ST_OK;
    case (req_r.action)
      ACT_INSERT: begin
        if (count_r >= CNT_W'(CAPACITY)) st_calc = ST_FULL;
        else if (req_r.position > count_r) st_calc = ST_BADPOS;
      end
      ACT_REMOVE, ACT_READ, ACT_OVERWRITE, ACT_COMPARE: begin
        if (count_r == '0) st_calc = ST_EMPTY;
        else if (req_r.position >= count_r) st_calc = ST_BADPOS;
      end
      ACT_SWAP: begin
        if (req_r.position >= count_r || pos2_ext >= count_r) st_calc = ST_BADPOS;
        else if (req_r.position == pos2_ext) st_calc = ST_SAME;
      end
      default: st_calc = ST_OK;
    endcase
  end

  always_comb begin
    case (cmd.rsel)
      RA_POS:  raddr = req_r.position[ADDR_W-1:0];
      RA_POS2: raddr = req_r.other_position[ADDR_W-1:0];
      RA_IDX:  raddr = idx_r[ADDR_W-1:0];
      default: raddr = neigh[ADDR_W-1:0];
    endcase
    case (cmd.wsel)
      WA_POS_VAL: begin
        waddr = req_r.position[ADDR_W-1:0];
        wdata = req_r.item_value;
      end
      WA_IDX_RD: begin
        waddr = idx_r[ADDR_W-1:0];
        wdata = rdata_r;
      end
      WA_POS_RD: begin
        waddr = req_r.position[ADDR_W-1:0];
        wdata = rdata_r;
      end
      default: begin
        waddr = req_r.other_position[ADDR_W-1:0];
        wdata = tmp_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[waddr] <= wdata;
    if (cmd.rd_en) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r   <= in_data;
      rd_r    <= '0;
      match_r <= 1'b0;
    end
    if (cmd.start) begin
      status_r <= st_calc;
      case (req_r.action)
        ACT_INSERT: idx_r <= count_r;
        ACT_REMOVE: idx_r <= req_r.position;
        default:    idx_r <= '0;
      endcase
    end else if (cmd.idx_step) begin
      idx_r <= (req_r.action == ACT_INSERT) ? idx_r - CNT_W'(1) : idx_r + CNT_W'(1);
    end
    if (cmd.cap_tmp) tmp_r <= rdata_r;
    if (cmd.cap_look) begin
      if (req_r.action == ACT_READ) rd_r <= rdata_r;
      else match_r <= (rdata_r == req_r.item_value);
    end
    if (cmd.scan_chk && rdata_r == req_r.item_value) match_r <= 1'b1;
    if (cmd.out_load) begin
      out_r.read_value <= rd_r;
      out_r.match      <= match_r;
      out_r.status     <= status_r;
      out_r.item_count <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_clr) count_r <= '0;
      else if (cmd.cnt_inc) count_r <= count_r + CNT_W'(1);
      else if (cmd.cnt_dec) count_r <= count_r - CNT_W'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign st.act        = req_r.action;
  assign st.err        = (st_calc != ST_OK);
  assign st.idx_eq_pos = (idx_r == req_r.position);
  assign st.idx_last   = ((idx_r + CNT_W'(1)) == count_r);
  assign st.idx_eq_cnt = (idx_r == count_r);
  assign st.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/indexed_list_engine_unit.sv
// Top level of the indexed list engine: a bounded ordered list of values.
// Depends on ile_pkg, ile_ctrl and ile_dp.
`timescale 1ns / 1ps
// Usage
//   The input channel (in_valid / in_ready / in_data) carries one request: an
//   action, a value and one or two positions. Every request yields exactly one
//   result on the output channel (out_valid / out_ready / out_data) holding the
//   value read, a match flag, a status code and the item count afterward.
//   Requests are handled one at a time. The cells live in a single-port-write,
//   single-port-read memory with registered read data, so the cost is set by
//   that memory port:
//     clear, overwrite and any rejected request: no memory read before the result;
//     read and compare-at: one read of cell p; swap: two reads, then two writes;
//     insert at p: items from p upward each move up a cell, read then written;
//     remove at p: items above p move down; member test walks every held item.
//   A new request is accepted in the cycle after the previous result is loaded.
//   The result sits in an output register; while the receiver stalls, the next
//   request is still accepted and worked on, and only its final hand-off waits.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; cell contents are not cleared, as only held cells are ever read.
module indexed_list_engine_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ile_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ile_pkg::out_t out_data
);
  import ile_pkg::*;

  // Commands from the controller and status flags back from the datapath.
  cmd_t  cmd;
  stat_t st;

  ile_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ile_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
